// File: src/tted_pkg.sv
// shared types and constants for the track event decoder
// no dependencies; used by every module under src
`timescale 1ns / 1ps
`default_nettype none

package tted_pkg;

    // defaults for top-level parameters and the config register
    localparam int          MAP_DEPTH_DEF   = 256;
    localparam int          QUEUE_DEPTH_DEF = 4;
    localparam logic [7:0]  MAX_LINES_RESET = 8'd64;

    // command codes in the low six bits of a command byte
    localparam logic [5:0]  CMD_VOLUME  = 6'h3d;
    localparam logic [5:0]  CMD_REST    = 6'h3e;
    localparam logic [5:0]  CMD_SPECIAL = 6'h3f;
    localparam logic [7:0]  BYTE_END    = 8'hff;
    // bit of a special command that selects jump over set speed
    localparam int          JUMP_BIT    = 7;

    localparam int          OUT_DATA_W  = 56;

    typedef enum logic [2:0] {
        EV_NOTE   = 3'd0,
        EV_VOLUME = 3'd1,
        EV_REST   = 3'd2,
        EV_END    = 3'd3,
        EV_JUMP   = 3'd4,
        EV_SPEED  = 3'd5
    } t_kind;

    // role of a byte within its command
    typedef enum logic [1:0] {
        ROLE_SINGLE  = 2'd0,
        ROLE_FIRST   = 2'd1,
        ROLE_OPERAND = 2'd2
    } t_role;

    typedef enum logic {
        PH_CMD     = 1'b0,
        PH_OPERAND = 1'b1
    } t_phase;

    // one classified byte as queued between front and back
    typedef struct packed {
        logic       start;
        t_role      role;
        logic [7:0] first;
        logic [7:0] second;
    } t_cmd;

    typedef struct packed {
        t_kind      kind;
        logic [8:0] line;
        logic [3:0] note_in_octave;
        logic [2:0] octave;
        logic [5:0] instrument;
        logic [3:0] volume;
        logic [7:0] rest_count;
        logic [7:0] speed_value;
        logic [7:0] jump_line;
        logic       track_done;
    } t_event;

endpackage

`default_nettype wire

// File: src/tted_front.sv
// front end: accepts track bytes and tags each with its role in a command
// depends on tted_pkg
`timescale 1ns / 1ps
`default_nettype none

module tted_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [7:0]         i_byte,
    input  wire logic               i_start,
    input  wire logic               i_full,
    output logic                    o_push,
    output tted_pkg::t_cmd          o_cmd
);

    tted_pkg::t_phase r_phase, n_phase;
    tted_pkg::t_phase phase_eff;
    logic [7:0]       r_held;
    logic             accept;
    logic             single;

    assign o_ready   = !i_full;
    assign accept    = i_valid && !i_full;
    // a track start drops any pending first byte
    assign phase_eff = i_start ? tted_pkg::PH_CMD : r_phase;
    assign single    = ((i_byte[5:0] == tted_pkg::CMD_REST) && (i_byte[7:6] != 2'd0))
                       || (i_byte == tted_pkg::BYTE_END);

    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            unique case (phase_eff)
                tted_pkg::PH_CMD:     n_phase = single ? tted_pkg::PH_CMD
                                                       : tted_pkg::PH_OPERAND;
                tted_pkg::PH_OPERAND: n_phase = tted_pkg::PH_CMD;
                default:              n_phase = tted_pkg::PH_CMD;
            endcase
        end
    end

    always_comb begin
        o_push       = accept;
        o_cmd.start  = i_start;
        o_cmd.role   = tted_pkg::ROLE_FIRST;
        o_cmd.first  = i_byte;
        o_cmd.second = 8'd0;
        unique case (phase_eff)
            tted_pkg::PH_CMD: begin
                o_cmd.role = single ? tted_pkg::ROLE_SINGLE : tted_pkg::ROLE_FIRST;
            end
            tted_pkg::PH_OPERAND: begin
                o_cmd.role   = tted_pkg::ROLE_OPERAND;
                o_cmd.first  = r_held;
                o_cmd.second = i_byte;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tted_pkg::PH_CMD;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (phase_eff == tted_pkg::PH_CMD)) begin
            r_held <= i_byte;
        end
    end

endmodule

`default_nettype wire

// File: src/tted_queue.sv
// short fifo of classified bytes between front and back
// depends on tted_pkg
`timescale 1ns / 1ps
`default_nettype none

module tted_queue #(
    parameter int DEPTH = tted_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire tted_pkg::t_cmd     i_data,
    output logic                    o_full,
    output logic                    o_valid,
    output tted_pkg::t_cmd          o_data,
    input  wire logic               i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tted_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = do_pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: src/tted_back.sv
// back end: line counter, offset-to-line map and event generation
// depends on tted_pkg; fed by tted_queue
`timescale 1ns / 1ps
`default_nettype none

module tted_back #(
    parameter int MAP_DEPTH = tted_pkg::MAP_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [7:0]         i_max_lines,
    input  wire logic               i_cmd_valid,
    input  wire tted_pkg::t_cmd     i_cmd,
    output logic                    o_cmd_pop,
    output logic                    o_ev_valid,
    input  wire logic               i_ev_ready,
    output tted_pkg::t_event        o_ev
);

    localparam int OFS_W = $clog2(MAP_DEPTH);
    // how many multiples of the depth fit below a byte value
    localparam int MAX_Q = 255 / MAP_DEPTH;

    logic [8:0]           r_line, n_line, line_eff;
    logic [OFS_W-1:0]     r_offset, n_offset, offset_eff;
    logic                 r_done, n_done, done_eff;
    logic [MAP_DEPTH-1:0] r_valid, n_valid;
    logic [7:0]           r_mem [MAP_DEPTH];
    logic [7:0]           r_rd;
    logic                 r_jval, jval;
    logic                 r_out_valid;
    tted_pkg::t_event     r_ev, ev;
    logic                 emit, wr_en, pop;
    logic [8:0]           max9;
    logic [5:0]           low;
    logic [3:0]           vol;
    logic [11:0]          sub;
    logic [OFS_W-1:0]     jidx;

    function automatic logic [OFS_W-1:0] ofs_inc(input logic [OFS_W-1:0] o);
        ofs_inc = (o == OFS_W'(MAP_DEPTH - 1)) ? '0 : o + OFS_W'(1);
    endfunction

    // low / 12 as (low * 43) >> 9, exact for six-bit values
    function automatic logic [2:0] div12(input logic [5:0] v);
        logic [11:0] w;
        w = (12'(v) << 5) + (12'(v) << 3) + (12'(v) << 1) + 12'(v);
        div12 = w[11:9];
    endfunction

    assign pop        = i_cmd_valid && (!r_out_valid || i_ev_ready);
    assign o_cmd_pop  = pop;
    assign o_ev_valid = r_out_valid;
    assign max9       = {1'b0, i_max_lines};
    assign low        = i_cmd.first[5:0];
    assign vol        = {i_cmd.second[1:0], i_cmd.first[7:6]};

    assign line_eff   = i_cmd.start ? 9'd0 : r_line;
    assign offset_eff = i_cmd.start ? '0 : r_offset;
    assign done_eff   = i_cmd.start ? 1'b0 : r_done;

    // jump target modulo the map depth
    always_comb begin
        sub = '0;
        for (int k = 1; k <= MAX_Q; k++) begin
            if (12'(i_cmd.second) >= 12'(k * MAP_DEPTH)) begin
                sub = 12'(k * MAP_DEPTH);
            end
        end
        jidx = OFS_W'(12'(i_cmd.second) - sub);
    end

    always_comb begin
        logic [2:0] q;
        q        = div12(low);
        n_line   = line_eff;
        n_offset = offset_eff;
        n_done   = done_eff;
        wr_en    = 1'b0;
        emit     = 1'b0;
        jval     = 1'b0;
        ev       = '0;
        ev.kind  = tted_pkg::EV_NOTE;
        ev.line  = line_eff;
        if (!done_eff) begin
            unique case (i_cmd.role)
                tted_pkg::ROLE_SINGLE, tted_pkg::ROLE_FIRST: begin
                    if (line_eff >= max9) begin
                        n_done = 1'b1;
                    end else begin
                        wr_en    = 1'b1;
                        n_offset = ofs_inc(offset_eff);
                        if (i_cmd.role == tted_pkg::ROLE_SINGLE) begin
                            emit = 1'b1;
                            if (low == tted_pkg::CMD_REST) begin
                                ev.kind       = tted_pkg::EV_REST;
                                ev.rest_count = {6'd0, i_cmd.first[7:6]};
                                n_line        = line_eff + 9'(i_cmd.first[7:6]);
                            end else begin
                                ev.kind = tted_pkg::EV_END;
                                n_line  = max9;
                            end
                        end
                    end
                end
                tted_pkg::ROLE_OPERAND: begin
                    emit     = 1'b1;
                    n_offset = ofs_inc(offset_eff);
                    priority if (low == tted_pkg::CMD_VOLUME) begin
                        ev.kind   = tted_pkg::EV_VOLUME;
                        ev.volume = vol;
                        n_line    = line_eff + 9'd1;
                    end else if (low == tted_pkg::CMD_REST) begin
                        ev.kind       = tted_pkg::EV_REST;
                        ev.rest_count = i_cmd.second;
                        n_line        = line_eff + 9'(i_cmd.second);
                    end else if (low == tted_pkg::CMD_SPECIAL) begin
                        if (i_cmd.first[tted_pkg::JUMP_BIT]) begin
                            ev.kind = tted_pkg::EV_JUMP;
                            jval    = r_valid[jidx];
                            n_line  = max9;
                        end else begin
                            ev.kind        = tted_pkg::EV_SPEED;
                            ev.speed_value = i_cmd.second;
                        end
                    end else begin
                        ev.kind           = tted_pkg::EV_NOTE;
                        ev.octave         = q + 3'd1;
                        ev.note_in_octave = 4'(low - {q, 3'b000} - {1'b0, q, 2'b00});
                        ev.instrument     = i_cmd.second[7:2];
                        ev.volume         = vol;
                        n_line            = line_eff + 9'd1;
                    end
                end
                default: ;
            endcase
            if (emit) begin
                n_done        = (n_line >= max9);
                ev.track_done = n_done;
            end
        end
    end

    always_comb begin
        n_valid = i_cmd.start ? '0 : r_valid;
        if (wr_en) begin
            n_valid[offset_eff] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line      <= 9'd0;
            r_offset    <= '0;
            r_done      <= 1'b0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else if (pop) begin
            r_line      <= n_line;
            r_offset    <= n_offset;
            r_done      <= n_done;
            r_valid     <= n_valid;
            r_out_valid <= emit;
        end else if (i_ev_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && emit) begin
            r_ev   <= ev;
            r_jval <= jval;
        end
    end

    // offset-to-line map, one write and one registered read a cycle, both only when a command is popped
    always_ff @(posedge i_clk) begin
        if (pop && wr_en) begin
            r_mem[offset_eff] <= line_eff[7:0];
        end
        if (pop) begin
            r_rd <= r_mem[jidx];
        end
    end

    always_comb begin
        o_ev           = r_ev;
        o_ev.jump_line = r_jval ? r_rd : 8'd0;
    end

    a_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line <= 9'd509)
        else $error("line counter out of range");

    a_end_sets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && emit && ((ev.kind == tted_pkg::EV_END) || (ev.kind == tted_pkg::EV_JUMP)))
        |=> r_done)
        else $error("end or jump did not finish the track");

    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && done_eff) |=> !r_out_valid)
        else $error("event produced after track end");

endmodule

`default_nettype wire

// File: src/tracker_track_event_decoder.sv
// top level of the track event decoder: ports, config register, front, queue, back
// depends on tted_pkg, tted_front, tted_queue, tted_back
// path: an accepted byte is written to the queue, then its event is registered at the output
// throughput: one byte per cycle sustained while the output takes events; while an event
//   waits on the output the queue takes up to four more beats before tready drops
// reset: synchronous, active low; clears phase, line, offset, done and all map
//   valid bits at once, so no clearing pass is needed; max_track_lines returns to 64
`timescale 1ns / 1ps
`default_nettype none

module tracker_track_event_decoder #(
    parameter int MAP_DEPTH   = tted_pkg::MAP_DEPTH_DEF,
    parameter int QUEUE_DEPTH = tted_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // track byte input
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [7:0]                     i_s_tdata,   // track_byte
    input  wire logic                           i_s_tuser,   // track_start
    // event output
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // line[8:0], note_in_octave, octave, instrument, volume, rest_count,
    // speed_value, jump_line[49:42], zero fill above
    output logic [tted_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    output logic [2:0]                          o_m_tuser,   // event_kind
    output logic                                o_m_tlast,   // track_done
    // max_track_lines write
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [7:0]                     i_cfg_data
);

    logic [7:0]        r_max_lines;
    logic              front_push;
    tted_pkg::t_cmd    front_cmd;
    logic              q_full;
    logic              q_valid;
    tted_pkg::t_cmd    q_cmd;
    logic              q_pop;
    tted_pkg::t_event  ev;

    // config writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_lines <= tted_pkg::MAX_LINES_RESET;
        end else if (i_cfg_valid) begin
            r_max_lines <= i_cfg_data;
        end
    end

    // front: tags each beat as single command, first byte or operand
    tted_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_byte  (i_s_tdata),
        .i_start (i_s_tuser),
        .i_full  (q_full),
        .o_push  (front_push),
        .o_cmd   (front_cmd)
    );

    // decouples byte intake from event output stalls
    tted_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_cmd),
        .i_pop   (q_pop)
    );

    // back: line tracking, map writes, jump lookups, output register
    tted_back #(
        .MAP_DEPTH (MAP_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_lines (r_max_lines),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_ev_valid  (o_m_tvalid),
        .i_ev_ready  (i_m_tready),
        .o_ev        (ev)
    );

    // pack the event fields, lowest field first
    assign o_m_tdata = {6'd0, ev.jump_line, ev.speed_value, ev.rest_count, ev.volume,
                        ev.instrument, ev.octave, ev.note_in_octave, ev.line};
    assign o_m_tuser = ev.kind;
    assign o_m_tlast = ev.track_done;

endmodule

`default_nettype wire
